// File: sv/tem_pkg.sv
`default_nettype none

package tem_pkg;

  localparam int CHAR_COUNT_DEFAULT = 256;
  localparam int KERN_ADDR_W = 16;

  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [7:0] CELL_WIDTH_RST = 8'd8;
  localparam logic [7:0] CELL_HEIGHT_RST = 8'd8;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_WIDTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FONT_TRACKING = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTRA_TRACKING = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LEADING = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_KERN_ENABLE = 3'd5;

  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_END   = 2'd1,
    REQ_WIDTH = 2'd2,
    REQ_KERN  = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t  req_type;
    logic [7:0] code;
    logic [7:0] second_code;
    logic [7:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [15:0] text_width;
    logic [15:0] text_height;
  } out_t;

endpackage

`default_nettype wire

// File: sv/text_extent_measure_unit.sv
// Text extent measurement for bitmap fonts.
// in channel (in_valid/in_ready/in_data): one request per cycle. Character
// requests stream a string, an end request closes it, width and kern write
// requests load the glyph tables. Only an end request yields a result.
// out channel (out_valid/out_ready/out_data): widest line and total height,
// both clamped to 0..65535.
// Config port (cfg_we/cfg_index/cfg_data): the user must see that it is written
// only while the block is idle; the block does not enforce this. Throughput: one
// request per cycle while in_ready is high. The width and kern tables are read
// with registered ports when the following request is taken, and the line sums
// are updated one stage later; out_valid rises as the end request leaves it.
// Reset: the kern table (65536 entries) is swept to zero, one entry a cycle,
// so in_ready stays low until the sweep is done; config writes are taken
// throughout. Width entries are cleared at once by valid flags.
// Stall: a waiting result sits in the output register and requests keep
// flowing until the next end request reaches the measuring stage; from then
// on in_ready stays low until the waiting result is taken.
`default_nettype none

module text_extent_measure_unit
  import tem_pkg::*;
#(
  parameter int CHAR_COUNT = CHAR_COUNT_DEFAULT
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output out_t                   out_data,
  input  wire                    cfg_we,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [7:0]              cfg_data
);

  localparam int WIDX_W = $clog2(CHAR_COUNT);
  localparam int KERN_DEPTH = 1 << KERN_ADDR_W;

  // configuration
  logic [7:0] cell_width, cell_height, font_tracking, extra_tracking, line_leading;
  logic       kern_enable;

  // string state at the request side
  logic       pending_valid;
  logic [7:0] pending_char;

  // kern table clearing sweep
  logic                   clearing;
  logic [KERN_ADDR_W-1:0] clr_addr;

  // tables
  logic [7:0]            width_mem [CHAR_COUNT];
  logic [CHAR_COUNT-1:0] width_valid;
  logic [7:0]            kern_mem [KERN_DEPTH];

  // measuring stage
  logic       s1_valid, s1_is_end, s1_consume, s1_wok;
  logic [7:0] s1_cur, s1_next, s1_wdata, s1_kern;

  logic signed [23:0] line_pos, widest_line, total_height;

  logic in_acc, s1_go, out_free, is_str, code_in_range, cur_in_range;
  logic [WIDX_W-1:0] code_idx, cur_idx;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_is_end || out_free);
  assign in_ready = !clearing && (!s1_valid || s1_go);
  assign in_acc   = in_valid && in_ready;
  assign is_str   = (in_data.req_type == REQ_CHAR) || (in_data.req_type == REQ_END);

  assign code_in_range = {1'b0, in_data.code} < 9'(CHAR_COUNT);
  assign cur_in_range  = {1'b0, pending_char} < 9'(CHAR_COUNT);
  assign code_idx      = in_data.code[WIDX_W-1:0];
  assign cur_idx       = pending_char[WIDX_W-1:0];

  // config registers, total height reload handled with the line sums
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width     <= CELL_WIDTH_RST;
      cell_height    <= CELL_HEIGHT_RST;
      font_tracking  <= '0;
      extra_tracking <= '0;
      line_leading   <= '0;
      kern_enable    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_WIDTH:     cell_width     <= cfg_data;
        CFG_CELL_HEIGHT:    cell_height    <= cfg_data;
        CFG_FONT_TRACKING:  font_tracking  <= cfg_data;
        CFG_EXTRA_TRACKING: extra_tracking <= cfg_data;
        CFG_LINE_LEADING:   line_leading   <= cfg_data;
        CFG_KERN_ENABLE:    kern_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_char  <= '0;
    end else if (in_acc) begin
      if (in_data.req_type == REQ_CHAR) begin
        pending_valid <= 1'b1;
        pending_char  <= in_data.code;
      end else if (in_data.req_type == REQ_END) begin
        pending_valid <= 1'b0;
        pending_char  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_valid <= '0;
    end else if (in_acc && in_data.req_type == REQ_WIDTH && code_in_range) begin
      width_valid[code_idx] <= 1'b1;
    end
  end

  // width table: written by width requests, read for the pending character
  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type == REQ_WIDTH && code_in_range)
      width_mem[code_idx] <= in_data.entry_value;
    if (in_acc && is_str) begin
      s1_wdata <= width_mem[cur_idx];
      s1_wok   <= cur_in_range && width_valid[cur_idx];
    end
  end

  // kern table: sweep or kern request writes, pair read for the pending character
  always_ff @(posedge clk) begin
    if (clearing)
      kern_mem[clr_addr] <= '0;
    else if (in_acc && in_data.req_type == REQ_KERN)
      kern_mem[{in_data.code, in_data.second_code}] <= in_data.entry_value;
    if (in_acc && is_str)
      s1_kern <= kern_mem[{pending_char, in_data.code}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && is_str) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_str) begin
      s1_is_end  <= in_data.req_type == REQ_END;
      s1_consume <= pending_valid;
      s1_cur     <= pending_char;
      s1_next    <= (in_data.req_type == REQ_END) ? 8'd0 : in_data.code;
    end
  end

  // advance of the pending character
  logic [7:0]         w_eff, base_w;
  logic               kern_on, trk_on;
  logic signed [11:0] adv;
  logic signed [9:0]  line_step, cfg_line_step;
  logic signed [24:0] lp_sum, th_sum;
  logic signed [23:0] lp_sat, th_sat, lp_c, th_c, wl_c;
  logic [7:0]         cfg_ch, cfg_ll;
  logic               reload;

  always_comb begin
    w_eff   = s1_wok ? s1_wdata : 8'd0;
    base_w  = (w_eff != 8'd0) ? w_eff : cell_width;
    kern_on = kern_enable && !s1_is_end && (s1_next != 8'd0);
    trk_on  = !s1_is_end && (s1_next != NEWLINE_CODE);
    adv     = $signed({4'b0, base_w});
    if (kern_on) adv = adv + $signed({{4{s1_kern[7]}}, s1_kern});
    if (trk_on)
      adv = adv + $signed({{4{font_tracking[7]}}, font_tracking})
                + $signed({{4{extra_tracking[7]}}, extra_tracking});
    if (s1_cur < FIRST_PRINTABLE) adv = '0;

    line_step = $signed({2'b0, cell_height}) + $signed({{2{line_leading[7]}}, line_leading});

    lp_sum = $signed({line_pos[23], line_pos}) + $signed({{13{adv[11]}}, adv});
    th_sum = $signed({total_height[23], total_height})
           + $signed({{15{line_step[9]}}, line_step});
    // saturate on signed overflow of the 24 bit sums
    if (lp_sum[24] != lp_sum[23]) lp_sat = lp_sum[24] ? 24'sh800000 : 24'sh7fffff;
    else                          lp_sat = lp_sum[23:0];
    if (th_sum[24] != th_sum[23]) th_sat = th_sum[24] ? 24'sh800000 : 24'sh7fffff;
    else                          th_sat = th_sum[23:0];

    lp_c = line_pos;
    th_c = total_height;
    if (s1_consume) begin
      if (s1_cur == NEWLINE_CODE) begin
        lp_c = '0;
        th_c = th_sat;
      end else begin
        lp_c = lp_sat;
      end
    end
    wl_c = (lp_c > widest_line) ? lp_c : widest_line;

    cfg_ch = (cfg_index == CFG_CELL_HEIGHT) ? cfg_data : cell_height;
    cfg_ll = (cfg_index == CFG_LINE_LEADING) ? cfg_data : line_leading;
    cfg_line_step = $signed({2'b0, cfg_ch}) + $signed({{2{cfg_ll[7]}}, cfg_ll});
    reload = cfg_we && !pending_valid &&
             ((cfg_index == CFG_CELL_HEIGHT) || (cfg_index == CFG_LINE_LEADING));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos     <= '0;
      widest_line  <= '0;
      total_height <= 24'(CELL_HEIGHT_RST);
    end else if (reload) begin
      total_height <= 24'(cfg_line_step);
    end else if (s1_go) begin
      if (s1_is_end) begin
        line_pos     <= '0;
        widest_line  <= '0;
        total_height <= 24'(line_step);
      end else begin
        line_pos     <= lp_c;
        widest_line  <= wl_c;
        total_height <= th_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // widest line is never negative, height may be
  always_ff @(posedge clk) begin
    if (s1_go && s1_is_end) begin
      out_data.text_width <= (wl_c[23:16] != 8'd0) ? 16'hffff : wl_c[15:0];
      if (th_c[23])                 out_data.text_height <= 16'd0;
      else if (th_c[22:16] != 7'd0) out_data.text_height <= 16'hffff;
      else                          out_data.text_height <= th_c[15:0];
    end
  end

`ifndef SYNTH
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request taken during kern table sweep");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> (s1_is_end && out_valid && !out_ready))
    else $error("measuring stage stalled without a blocked result");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_is_end) |=> out_valid)
    else $error("end request produced no result");

  a_widest_non_negative: assert property (@(posedge clk) disable iff (rst)
    !widest_line[23])
    else $error("widest line went negative");

  a_end_closes_string: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.req_type == REQ_END) |=> !pending_valid)
    else $error("string still open after end request");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_text_extent_measure_unit.sv
`timescale 1ns / 100ps

module tb_text_extent_measure_unit;
  import tem_pkg::*;

  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;

  // indexes past the last register; writes to these must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  class extent_scoreboard;
    logic [7:0] glyph_width [256];
    logic [7:0] kern_adjust [65536];
    logic [7:0] cell_w, cell_h, font_trk, extra_trk, leading;
    bit kern_on;
    bit char_held;
    logic [7:0] held_char;
    int line_x, widest, height;
    out_t extents_due[$];
    int mismatches;

    function new();
      foreach (glyph_width[i]) glyph_width[i] = '0;
      foreach (kern_adjust[i]) kern_adjust[i] = '0;
      cell_w = CELL_WIDTH_RST;
      cell_h = CELL_HEIGHT_RST;
      font_trk = '0;
      extra_trk = '0;
      leading = '0;
      kern_on = 1'b0;
      mismatches = 0;
      restart_string();
    endfunction

    function int row_pitch();
      return int'(cell_h) + int'($signed(leading));
    endfunction

    function int sat24(int v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function logic [15:0] sat16(int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
    endfunction

    function void restart_string();
      char_held = 1'b0;
      held_char = '0;
      line_x = 0;
      widest = 0;
      height = row_pitch();
    endfunction

    function int glyph_advance(logic [7:0] ch, logic [7:0] nxt, bit at_end);
      int adv;
      if (ch < FIRST_PRINTABLE) return 0;
      adv = (glyph_width[ch] != 0) ? int'(glyph_width[ch]) : int'(cell_w);
      if (kern_on && !at_end && nxt != 0)
        adv += int'($signed(kern_adjust[{ch, nxt}]));
      if (!at_end && nxt != NEWLINE_CODE)
        adv += int'($signed(font_trk)) + int'($signed(extra_trk));
      return adv;
    endfunction

    // the held character is settled only once its successor is known
    function void settle_held(logic [7:0] nxt, bit at_end);
      if (held_char == NEWLINE_CODE) begin
        line_x = 0;
        height = sat24(height + row_pitch());
      end else begin
        line_x = sat24(line_x + glyph_advance(held_char, nxt, at_end));
      end
      if (line_x > widest) widest = line_x;
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_CELL_WIDTH: cell_w = val;
        CFG_CELL_HEIGHT: cell_h = val;
        CFG_FONT_TRACKING: font_trk = val;
        CFG_EXTRA_TRACKING: extra_trk = val;
        CFG_LINE_LEADING: leading = val;
        CFG_KERN_ENABLE: kern_on = val[0];
        default: return;
      endcase
      if ((idx == CFG_CELL_HEIGHT || idx == CFG_LINE_LEADING) && !char_held)
        height = row_pitch();
    endfunction

    function void note_request(in_t req);
      out_t res;
      case (req.req_type)
        REQ_CHAR: begin
          if (char_held) settle_held(req.code, 1'b0);
          held_char = req.code;
          char_held = 1'b1;
        end
        REQ_END: begin
          if (char_held) settle_held(8'd0, 1'b1);
          res.text_width = sat16(widest);
          res.text_height = sat16(height);
          extents_due.push_back(res);
          restart_string();
        end
        REQ_WIDTH: glyph_width[req.code] = req.entry_value;
        default: kern_adjust[{req.code, req.second_code}] = req.entry_value;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (extents_due.size() == 0) begin
        $error("extent result with no end request waiting: %h", got);
        mismatches++;
        return;
      end
      want = extents_due.pop_front();
      if (got.text_width !== want.text_width) begin
        $error("text_width: expected %0d, got %0d", want.text_width, got.text_width);
        mismatches++;
      end
      if (got.text_height !== want.text_height) begin
        $error("text_height: expected %0d, got %0d", want.text_height, got.text_height);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  extent_scoreboard sb = new();
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  logic [7:0] pair_codes [8] = '{8'd32, 8'd65, 8'd86, 8'd84, 8'd111, 8'd87, 8'd46, 8'd255};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_extent_measure_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // result side: random back-pressure, plus a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = STALL_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic in_t mk_req(req_type_t kind, logic [7:0] c, logic [7:0] s,
                                 logic [7:0] e);
    in_t r;
    r.req_type = kind;
    r.code = c;
    r.second_code = s;
    r.entry_value = e;
    return r;
  endfunction

  function automatic logic [7:0] pick_code();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return pair_codes[$urandom_range(7)];
    if (roll < 55) return NEWLINE_CODE;
    if (roll < 65) return 8'($urandom_range(31));
    return 8'($urandom_range(255));
  endfunction

  function automatic in_t random_body_req();
    int roll;
    logic [7:0] c, s, e;
    roll = $urandom_range(99);
    if (roll < 8) begin
      c = ($urandom_range(1) != 0) ? pair_codes[$urandom_range(7)] : 8'($urandom_range(255));
      e = ($urandom_range(9) < 3) ? 8'd0 : 8'($urandom_range(255));
      return mk_req(REQ_WIDTH, c, 8'($urandom_range(255)), e);
    end
    if (roll < 16) begin
      if ($urandom_range(9) < 7) begin
        c = pair_codes[$urandom_range(7)];
        s = pair_codes[$urandom_range(7)];
      end else begin
        c = 8'($urandom_range(255));
        s = 8'($urandom_range(255));
      end
      return mk_req(REQ_KERN, c, s, 8'($urandom_range(255)));
    end
    return mk_req(REQ_CHAR, pick_code(), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endfunction

  task automatic push_req(input in_t req);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic send_char(input logic [7:0] c);
    push_req(mk_req(REQ_CHAR, c, 8'($urandom_range(255)), 8'($urandom_range(255))));
  endtask

  task automatic send_end();
    push_req(mk_req(REQ_END, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255))));
  endtask

  // wait out every result, then the pipeline tail behind it
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.extents_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.note_config(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(input logic [7:0] cw, input logic [7:0] ch,
                             input logic [7:0] ft, input logic [7:0] et,
                             input logic [7:0] ll, input logic [7:0] ke);
    cfg_write(CFG_CELL_WIDTH, cw);
    cfg_write(CFG_CELL_HEIGHT, ch);
    cfg_write(CFG_FONT_TRACKING, ft);
    cfg_write(CFG_EXTRA_TRACKING, et);
    cfg_write(CFG_LINE_LEADING, ll);
    cfg_write(CFG_KERN_ENABLE, ke);
  endtask

  task automatic random_traffic(input int quota);
    int sent;
    int len;
    sent = 0;
    while (sent < quota) begin
      len = $urandom_range(14);
      for (int i = 0; i < len; i++) push_req(random_body_req());
      send_end();
      sent += len + 1;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // spare indexes must leave everything untouched
    cfg_write(CFG_SPARE_LO, 8'hFF);
    cfg_write(CFG_SPARE_HI, 8'h5A);

    // empty string, then a short string over the default registers
    send_end();
    push_req(mk_req(REQ_WIDTH, 8'd65, 8'd0, 8'd12));
    push_req(mk_req(REQ_WIDTH, 8'd255, 8'hFF, 8'd255));
    push_req(mk_req(REQ_WIDTH, 8'd0, 8'd0, 8'hFF));
    push_req(mk_req(REQ_KERN, 8'd65, 8'd86, 8'hFC));
    push_req(mk_req(REQ_KERN, 8'd255, 8'd255, 8'h80));
    push_req(mk_req(REQ_KERN, 8'd86, 8'd65, 8'h7F));
    send_char(8'd65);
    send_char(8'd86);
    send_char(8'd7);
    send_char(NEWLINE_CODE);
    send_char(8'd255);
    send_char(8'd255);
    send_char(8'd32);
    send_end();

    settle();
    load_config(8'd3, 8'd10, 8'd2, 8'hFF, 8'hFE, 8'd1);
    send_char(8'd65);
    send_char(8'd86);
    send_char(8'd65);
    send_char(NEWLINE_CODE);
    send_char(8'd255);
    send_char(8'd255);
    send_end();

    // register writes with a string open: height change only counts from the next newline
    send_char(8'd86);
    send_char(8'd65);
    settle();
    cfg_write(CFG_CELL_HEIGHT, 8'd20);
    cfg_write(CFG_CELL_WIDTH, 8'd1);
    send_char(NEWLINE_CODE);
    send_char(8'd40);
    send_end();

    for (int p = 0; p < 6; p++) begin
      settle();
      steady = (p == 0);
      case (p)
        1: load_config(8'd255, 8'd255, 8'd127, 8'd127, 8'd127, 8'd1);
        2: load_config(8'd0, 8'd0, 8'h80, 8'h80, 8'h80, 8'hFF);
        3: load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        default: load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      if (p == 1) begin
        hold_req = 1'b1;
        // long lines and many newlines to drive both outputs into saturation
        push_req(mk_req(REQ_WIDTH, 8'd200, 8'd0, 8'd255));
        for (int i = 0; i < 140; i++) send_char(8'd200);
        send_end();
        for (int i = 0; i < 175; i++) send_char(NEWLINE_CODE);
        send_end();
      end
      random_traffic(160);
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tem_pkg.sv
sv/text_extent_measure_unit.sv
tb/sv/tb_text_extent_measure_unit.sv
